// ----- rtl/swm_pkg.sv -----
package swm_pkg;

	// Default depth of the window and width of one sample.
	localparam int WINDOW_MAX = 64;
	localparam int SAMPLE_BITS = 16;

	// Width of the window size register and its value after reset.
	localparam int CFG_W = 7;
	localparam int SIZE_RESET = 3;

	// What a cell shows its neighbors: whether it holds a sample and whether
	// that sample is greater than the incoming one (an empty cell counts as greater).
	typedef struct packed {
		logic vld;
		logic gt;
	} nbr_t;

endpackage

// ----- rtl/swm_if.sv -----
// Sample stream channel.
interface swm_sample_if #(
	parameter int W = swm_pkg::SAMPLE_BITS
);
	logic         valid;
	logic         ready;
	logic [W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// Median result channel.
interface swm_median_if #(
	parameter int W = swm_pkg::SAMPLE_BITS
);
	logic         valid;
	logic         ready;
	logic [W-1:0] median;

	modport source (output valid, output median, input ready);
	modport sink (input valid, input median, output ready);
endinterface

// Window size register write channel.
interface swm_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [swm_pkg::CFG_W-1:0] window_size;

	modport source (output valid, output window_size, input ready);
	modport sink (input valid, input window_size, output ready);
endinterface

// ----- rtl/swm_cell.sv -----
// One place of the sorted window. The cells together keep the window in
// ascending order, empty cells at the high end. On every word a cell takes
// its new content from itself or a neighbor: the oldest sample drops out,
// the ones above it slide down one place, and the new sample goes in at its rank.
module swm_cell #(
	parameter int VAL_W = swm_pkg::SAMPLE_BITS,
	parameter int AGE_W = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               upd,
	input  logic               clr,
	input  logic [VAL_W-1:0]   smp,
	input  logic [AGE_W-1:0]   age_last,
	input  logic               dl_prv,
	input  logic               dl_self,
	input  swm_pkg::nbr_t      prv,
	input  logic [VAL_W-1:0]   prv_val,
	input  logic [AGE_W-1:0]   prv_age,
	input  swm_pkg::nbr_t      nxt,
	input  logic [VAL_W-1:0]   nxt_val,
	input  logic [AGE_W-1:0]   nxt_age,
	output swm_pkg::nbr_t      own,
	output logic               del,
	output logic [VAL_W-1:0]   val_q,
	output logic [AGE_W-1:0]   age_q
);

	logic             vld_q;
	swm_pkg::nbr_t    r_cur;
	logic [VAL_W-1:0] r_cur_val;
	logic [AGE_W-1:0] r_cur_age;
	swm_pkg::nbr_t    r_prv;
	logic [VAL_W-1:0] r_prv_val;
	logic [AGE_W-1:0] r_prv_age;
	logic             n_vld;
	logic [VAL_W-1:0] n_val;
	logic [AGE_W-1:0] n_age;

	// Flags shown to the neighbors and to the delete search.
	assign own.vld = vld_q;
	assign own.gt = !vld_q || (val_q > smp);
	assign del = vld_q && (age_q == age_last);

	// Contents after the oldest sample is taken out: above the deleted place
	// everything has moved down by one.
	always_comb begin
		if (dl_self) begin
			r_cur = nxt;
			r_cur_val = nxt_val;
			r_cur_age = nxt_age;
		end else begin
			r_cur = own;
			r_cur_val = val_q;
			r_cur_age = age_q;
		end
		if (dl_prv) begin
			r_prv = own;
			r_prv_val = val_q;
			r_prv_age = age_q;
		end else begin
			r_prv = prv;
			r_prv_val = prv_val;
			r_prv_age = prv_age;
		end
	end

	// Insertion of the new sample at the first place whose content is greater.
	always_comb begin
		priority if (!r_cur.gt) begin
			n_vld = r_cur.vld;
			n_val = r_cur_val;
			n_age = r_cur_age + AGE_W'(1);
		end else if (!r_prv.gt) begin
			n_vld = 1'b1;
			n_val = smp;
			n_age = '0;
		end else begin
			n_vld = r_prv.vld;
			n_val = r_prv_val;
			n_age = r_prv_age + AGE_W'(1);
		end
	end

	// Occupancy flag; a size write empties the window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (clr) begin
			vld_q <= 1'b0;
		end else if (upd) begin
			vld_q <= n_vld;
		end
	end

	// Sample value and its age in words.
	always_ff @(posedge clk) begin
		if (upd) begin
			val_q <= n_val;
			age_q <= n_age;
		end
	end

endmodule

// ----- rtl/sliding_window_median_core.sv -----
// Channel   Dir  Payload               Handshake
// cfg       in   window_size [6:0]     valid/ready, ready always high
// samples   in   sample [W-1:0]        valid/ready
// medians   out  median [W-1:0]        valid/ready
//
// One sample per cycle unless stalled; the cell row re-sorts on every taken word.
// Medians start with the window-filling sample; each waits pending for a free output.
// Reset empties the window and sets its size to three; a size write empties it too.
// A stalled median holds the sample side only when a second median is already waiting.
module sliding_window_median_core #(
	parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX,
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS
) (
	input logic                 clk,
	input logic                 arst_n,
	swm_cfg_if.sink             cfg,
	swm_sample_if.sink          samples,
	swm_median_if.source        medians
);

	localparam int SIZE_W = $clog2(WINDOW_MAX + 1);
	localparam int AGE_W = $clog2(WINDOW_MAX);
	localparam int CMP_W = (SIZE_W > swm_pkg::CFG_W) ? SIZE_W : swm_pkg::CFG_W;
	localparam int RST_SIZE = (swm_pkg::SIZE_RESET > WINDOW_MAX) ? WINDOW_MAX :
		swm_pkg::SIZE_RESET;

	logic [SIZE_W-1:0]      size_q;
	logic [AGE_W-1:0]       age_last_q;
	logic [AGE_W-1:0]       rank_q;
	logic [SIZE_W-1:0]      fill_q;
	logic                   pend_s1;
	logic                   out_vld_q;
	logic [SAMPLE_BITS-1:0] median_q;

	logic                   cfg_wr;
	logic [CMP_W-1:0]       wsz;
	logic [SIZE_W-1:0]      eff_size;
	logic [AGE_W-1:0]       eff_last;
	logic                   acc;
	logic                   move;
	logic                   full;
	logic                   produce;

	swm_pkg::nbr_t          nbr [WINDOW_MAX];
	logic [SAMPLE_BITS-1:0] cval [WINDOW_MAX];
	logic [AGE_W-1:0]       cage [WINDOW_MAX];
	logic [WINDOW_MAX-1:0]  del_vec;
	logic [WINDOW_MAX-1:0]  dl_vec;

	// Size write: zero means one sample, anything above the depth saturates.
	assign cfg.ready = 1'b1;
	assign cfg_wr = cfg.valid;
	assign wsz = CMP_W'(cfg.window_size);

	always_comb begin
		priority if (wsz == '0) begin
			eff_size = SIZE_W'(1);
		end else if (wsz > CMP_W'(WINDOW_MAX)) begin
			eff_size = SIZE_W'(WINDOW_MAX);
		end else begin
			eff_size = wsz[SIZE_W-1:0];
		end
		eff_last = AGE_W'(eff_size - SIZE_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(RST_SIZE);
			age_last_q <= AGE_W'(RST_SIZE - 1);
			rank_q <= AGE_W'((RST_SIZE - 1) / 2);
		end else if (cfg_wr) begin
			size_q <= eff_size;
			age_last_q <= eff_last;
			rank_q <= eff_last >> 1;
		end
	end

	// Handshake: a new word waits only while a median is pending behind a full output.
	assign move = pend_s1 && (!out_vld_q || medians.ready);
	assign samples.ready = !pend_s1 || move;
	assign acc = samples.valid && samples.ready;
	assign full = (fill_q == size_q);
	assign produce = full || ((fill_q + SIZE_W'(1)) == size_q);

	// Fill count of the window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cfg_wr) begin
			fill_q <= '0;
		end else if (acc && !full) begin
			fill_q <= fill_q + SIZE_W'(1);
		end
	end

	// Pending median and output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (acc) begin
				pend_s1 <= produce;
			end else if (move) begin
				pend_s1 <= 1'b0;
			end
			if (move) begin
				out_vld_q <= 1'b1;
			end else if (medians.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Median read from the sorted row at the rank of the lower middle.
	always_ff @(posedge clk) begin
		if (move) begin
			median_q <= cval[rank_q];
		end
	end

	assign medians.valid = out_vld_q;
	assign medians.median = median_q;

	// Row of sorting cells; each cell learns whether the oldest sample sits at
	// or below its own place.
	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		swm_pkg::nbr_t          prv;
		swm_pkg::nbr_t          nxt;
		logic [SAMPLE_BITS-1:0] prv_val;
		logic [SAMPLE_BITS-1:0] nxt_val;
		logic [AGE_W-1:0]       prv_age;
		logic [AGE_W-1:0]       nxt_age;
		logic                   dl_prv;

		assign dl_vec[i] = |del_vec[i:0];

		if (i == 0) begin : g_lo
			assign prv = '{vld: 1'b0, gt: 1'b0};
			assign prv_val = '0;
			assign prv_age = '0;
			assign dl_prv = 1'b0;
		end else begin : g_mid
			assign prv = nbr[i-1];
			assign prv_val = cval[i-1];
			assign prv_age = cage[i-1];
			assign dl_prv = dl_vec[i-1];
		end

		if (i == WINDOW_MAX - 1) begin : g_hi
			assign nxt = '{vld: 1'b0, gt: 1'b1};
			assign nxt_val = '0;
			assign nxt_age = '0;
		end else begin : g_low
			assign nxt = nbr[i+1];
			assign nxt_val = cval[i+1];
			assign nxt_age = cage[i+1];
		end

		swm_cell #(
			.VAL_W (SAMPLE_BITS),
			.AGE_W (AGE_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.upd      (acc),
			.clr      (cfg_wr),
			.smp      (samples.sample),
			.age_last (age_last_q),
			.dl_prv   (dl_prv),
			.dl_self  (dl_vec[i]),
			.prv      (prv),
			.prv_val  (prv_val),
			.prv_age  (prv_age),
			.nxt      (nxt),
			.nxt_val  (nxt_val),
			.nxt_age  (nxt_age),
			.own      (nbr[i]),
			.del      (del_vec[i]),
			.val_q    (cval[i]),
			.age_q    (cage[i])
		);
	end

endmodule

// ----- rtl/swm_check.sv -----
// Port-level checks of the median filter.
module swm_check #(
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   cfg_valid,
	input logic                   cfg_ready,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] out_median
);

	// A stalled median word keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_median))
		else $error("median changed while stalled");

	// The size register never back-pressures.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("size write refused");

	// The sample side stalls only when a median waits at a blocked output.
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("sample side stalled without cause");

	// A new median word traces back to an earlier accepted sample.
	a_out_lat: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("median without a sample two cycles before");

endmodule

bind sliding_window_median_core swm_check #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_swm_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.cfg_valid  (cfg.valid),
	.cfg_ready  (cfg.ready),
	.in_valid   (samples.valid),
	.in_ready   (samples.ready),
	.out_valid  (medians.valid),
	.out_ready  (medians.ready),
	.out_median (medians.median)
);
